// File: sv/deqe_pkg.sv
`default_nettype none

package deqe_pkg;

    typedef enum logic [1:0] {
        REQ_PUSH   = 2'd0,
        REQ_POP    = 2'd1,
        REQ_READ   = 2'd2,
        REQ_REMOVE = 2'd3
    } t_req_kind;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_NONE = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    // Broadcast control that every cell sees during the execute cycle.
    typedef struct packed {
        logic      exec;
        t_req_kind kind;
        logic      tail;
        logic      full;
        logic      empty;
        logic      found;
    } t_cell_ctl;

endpackage

`default_nettype wire

// File: sv/deqe_cell.sv
`default_nettype none

module deqe_cell
    import deqe_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                  i_clk,
    input  wire t_cell_ctl             i_ctl,
    input  wire logic [DATA_WIDTH-1:0] i_word,
    input  wire logic [DATA_WIDTH-1:0] i_prev,
    input  wire logic [DATA_WIDTH-1:0] i_next,
    input  wire logic                  i_active,
    input  wire logic                  i_at_end,
    input  wire logic                  i_seen_h,
    input  wire logic                  i_seen_t,
    output logic                       o_seen_h,
    output logic                       o_seen_t,
    output logic [DATA_WIDTH-1:0]      o_data
);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;
    logic                  match;
    logic                  past_hit;

    assign match    = i_active && (r_data == i_word);
    assign o_seen_h = i_seen_h | match;
    assign o_seen_t = i_seen_t | match;
    assign o_data   = r_data;

    // A cell at or beyond the removed entry takes its neighbor toward the tail.
    // From the tail end the removed entry is the last match, so no later match.
    assign past_hit = i_ctl.tail ? !i_seen_t : (i_seen_h | match);

    always_comb begin
        n_data = r_data;
        if (i_ctl.exec) begin
            case (i_ctl.kind)
                REQ_PUSH: begin
                    if (!i_ctl.full) begin
                        if (i_ctl.tail) begin
                            if (i_at_end) n_data = i_word;
                        end else if (i_active || i_at_end) begin
                            n_data = i_prev;
                        end
                    end
                end
                REQ_POP: begin
                    if (!i_ctl.empty && !i_ctl.tail && i_active) n_data = i_next;
                end
                REQ_REMOVE: begin
                    if (i_ctl.found && i_active && past_hit) n_data = i_next;
                end
                default: n_data = r_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

endmodule

`default_nettype wire

// File: sv/double_ended_queue_engine_unit.sv
// A request accepted while idle moves the unit to the execute state, and its result is registered as that state ends.
// No new request is taken during the execute state or while a held result is stalled; in the
// execute state the whole row of cells compares and shifts in parallel.
// Reset clears the entry count and the handshake state; entry words are not cleared.
`default_nettype none

module double_ended_queue_engine_unit
    import deqe_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_req_type,
    input  wire logic        i_end_sel,
    input  wire logic [31:0] i_data_in,
    input  wire logic [3:0]  i_position,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [31:0]      o_data_out,
    output logic [1:0]       o_status,
    output logic [4:0]       o_length
);

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int IW   = $clog2(DEPTH);
    localparam int CMPW = (CW > 4) ? CW : 4;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state                r_state;
    t_state                n_state;
    t_req_kind             r_kind;
    logic                  r_tail;
    logic [DATA_WIDTH-1:0] r_word;
    logic [3:0]            r_pos;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;
    logic                  r_out_valid;
    logic [31:0]           r_data_out;
    logic [31:0]           n_data_out;
    t_status               r_status;
    t_status               n_status;

    logic                  in_acc;
    logic                  out_acc;
    t_cell_ctl             ctl;
    logic                  full;
    logic                  empty;
    logic                  found;
    logic                  pos_ok;
    logic [CW-1:0]         offset;
    logic [CW-1:0]         pick;
    logic [DATA_WIDTH-1:0] picked;

    logic [DATA_WIDTH-1:0] cell_data [DEPTH];
    logic [DEPTH:0]        seen_h;
    logic [DEPTH:0]        seen_t;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_acc    = r_out_valid && !i_out_stall;
    assign o_in_stall = (r_state == S_EXEC) || (r_out_valid && i_out_stall);

    assign full   = (r_count == CW'(DEPTH));
    assign empty  = (r_count == '0);
    assign found  = seen_h[DEPTH];
    assign pos_ok = CMPW'(r_pos) < CMPW'(r_count);

    assign ctl.exec  = (r_state == S_EXEC);
    assign ctl.kind  = r_kind;
    assign ctl.tail  = r_tail;
    assign ctl.full  = full;
    assign ctl.empty = empty;
    assign ctl.found = found;

    assign seen_h[0]     = 1'b0;
    assign seen_t[DEPTH] = 1'b0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] prev_data;
        logic [DATA_WIDTH-1:0] next_data;

        if (g == 0) begin : g_first
            assign prev_data = r_word;
        end else begin : g_mid
            assign prev_data = cell_data[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign next_data = cell_data[g];
        end else begin : g_inner
            assign next_data = cell_data[g+1];
        end

        deqe_cell #(
            .DATA_WIDTH(DATA_WIDTH)
        ) u_cell (
            .i_clk    (i_clk),
            .i_ctl    (ctl),
            .i_word   (r_word),
            .i_prev   (prev_data),
            .i_next   (next_data),
            .i_active (CW'(g) < r_count),
            .i_at_end (CW'(g) == r_count),
            .i_seen_h (seen_h[g]),
            .i_seen_t (seen_t[g+1]),
            .o_seen_h (seen_h[g+1]),
            .o_seen_t (seen_t[g]),
            .o_data   (cell_data[g])
        );
    end

    // Pop reads offset zero from its end; read uses the requested position.
    assign offset = (r_kind == REQ_POP) ? '0 : CW'(r_pos);
    assign pick   = r_tail ? (r_count - CW'(1) - offset) : offset;
    assign picked = cell_data[pick[IW-1:0]];

    always_comb begin
        n_count    = r_count;
        n_data_out = '0;
        n_status   = ST_OK;
        case (r_kind)
            REQ_PUSH: begin
                if (full) n_status = ST_FULL;
                else      n_count  = r_count + CW'(1);
            end
            REQ_POP: begin
                if (empty) begin
                    n_status = ST_NONE;
                end else begin
                    n_data_out = 32'(picked);
                    n_count    = r_count - CW'(1);
                end
            end
            REQ_READ: begin
                if (pos_ok) n_data_out = 32'(picked);
                else        n_status   = ST_NONE;
            end
            REQ_REMOVE: begin
                if (found) begin
                    n_data_out = 32'(r_word);
                    n_count    = r_count - CW'(1);
                end else begin
                    n_status = ST_NONE;
                end
            end
            default: n_status = ST_NONE;
        endcase
    end

    always_comb begin
        case (r_state)
            S_IDLE:  n_state = in_acc ? S_EXEC : S_IDLE;
            S_EXEC:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_EXEC) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (out_acc) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_kind <= t_req_kind'(i_req_type);
            r_tail <= i_end_sel;
            r_word <= DATA_WIDTH'(i_data_in);
            r_pos  <= i_position;
        end
        if (r_state == S_EXEC) begin
            r_data_out <= n_data_out;
            r_status   <= n_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_data_out  = r_data_out;
    assign o_status    = r_status;
    assign o_length    = 5'(r_count);

endmodule

`default_nettype wire
